>>> src/arr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and state codes of the audio rate resampler.
package arr_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_RUN     = 32;

	localparam int STEP_W = 20;
	localparam int CHAN_W = 2;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 2;

	// position word: holds limit (1.5 in fixed point) plus one full step
	localparam int POS_W  = ((STEP_W > FRAC_BITS + 1) ? STEP_W : FRAC_BITS + 1) + 1;
	localparam int RUN_W  = $clog2(MAX_RUN);
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_PHASE_STEP    = 2'd0;
	localparam reg_idx_t REG_INTERP_MODE   = 2'd1;
	localparam reg_idx_t REG_CHANNEL_COUNT = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(65536);
	localparam logic [CHAN_W-1:0] CHAN_RESET  = CHAN_W'(1);
	localparam logic [CHAN_W-1:0] CHAN_STEREO = CHAN_W'(2);
	localparam logic              MODE_LINEAR = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [POS_W-1:0]              pos_t;
	typedef logic [RUN_W-1:0]              run_t;

	localparam pos_t ONE_POS  = POS_W'(1 << FRAC_BITS);
	localparam pos_t HALF_POS = POS_W'(1 << (FRAC_BITS - 1));

	typedef struct packed {
		logic [STEP_W-1:0] phase_step;
		logic              linear;
		logic              stereo;
	} cfg_t;

	typedef struct packed {
		logic                 load;
		sample_t              a;
		sample_t              b;
		logic [FRAC_BITS-1:0] frac;
	} lerp_req_t;

	typedef struct packed {
		logic    valid;
		sample_t left;
		sample_t right;
		logic    last;
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_L,
		ST_MUL_R,
		ST_EMIT,
		ST_DONE
	} seq_state_t;

endpackage

>>> src/arr_if.sv
`timescale 1ns / 1ps
// Frame and result stream interfaces of the audio rate resampler.
interface arr_frame_if import arr_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t in_left;
	sample_t in_right;
	logic    end_of_block;

	modport source(output valid, in_left, in_right, end_of_block, input ready);
	modport sink(input valid, in_left, in_right, end_of_block, output ready);
endinterface

interface arr_result_if import arr_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t out_left;
	sample_t out_right;
	logic    last_of_run;

	modport source(output valid, out_left, out_right, last_of_run, input ready);
	modport sink(input valid, out_left, out_right, last_of_run, output ready);
endinterface

>>> src/arr_lerp_unit.sv
`timescale 1ns / 1ps
// Shared interpolation unit: registered (b - a) * frac, then a + floor(product >> FRAC_BITS).
module arr_lerp_unit import arr_pkg::*; (
	input  logic      clk,
	input  lerp_req_t req,
	output sample_t   result
);

	logic signed [DIFF_W-1:0]      diff;
	logic signed [PROD_W-1:0]      prod_s1;
	sample_t                       base_s1;
	logic signed [PROD_W-1:0]      shifted;
	logic signed [SAMPLE_BITS+1:0] sum;

	assign diff = $signed({req.b[SAMPLE_BITS-1], req.b}) - $signed({req.a[SAMPLE_BITS-1], req.a});

	always_ff @(posedge clk) begin
		if (req.load) begin
			prod_s1 <= PROD_W'(diff) * PROD_W'($signed({1'b0, req.frac}));
			base_s1 <= req.a;
		end
	end

	// arithmetic shift gives the floor for negative products
	assign shifted = prod_s1 >>> FRAC_BITS;
	assign sum     = $signed({{2{base_s1[SAMPLE_BITS-1]}}, base_s1}) + shifted[SAMPLE_BITS+1:0];
	assign result  = sum[SAMPLE_BITS-1:0];

endmodule

>>> src/arr_seq.sv
`timescale 1ns / 1ps
// Sequencer: phase accumulator, run counter and frame state of the resampler.
module arr_seq import arr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	arr_frame_if.sink   frame,
	input  logic        slot_free,
	input  sample_t     lerp_result,
	output lerp_req_t   lerp_req,
	output emit_t       emit
);

	seq_state_t state_q, state_d;
	pos_t       t_q, limit_q, phase_q;
	run_t       n_q;
	logic       have_prev_q;
	sample_t    prev_l_q, prev_r_q;
	sample_t    cur_l_q, cur_r_q, res_l_q;
	logic       eob_q;

	pos_t       t_next, t_fin, limit_sel;
	logic       more, last;

	assign t_next = t_q + POS_W'(cfg.phase_step);
	assign more   = t_q < limit_q;
	assign last   = (t_next >= limit_q) || (n_q == RUN_W'(MAX_RUN - 1));
	// a capped run jumps to the frame's limit
	assign t_fin  = more ? limit_q : t_q;

	always_comb begin
		if (!have_prev_q)
			limit_sel = cfg.linear ? '0 : HALF_POS;
		else
			limit_sel = cfg.linear ? ONE_POS : ONE_POS + HALF_POS;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (frame.valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (!more)
					state_d = ST_DONE;
				else if (cfg.linear)
					state_d = ST_MUL_L;
				else
					state_d = ST_EMIT;
			end
			ST_MUL_L: state_d = cfg.stereo ? ST_MUL_R : ST_EMIT;
			ST_MUL_R: state_d = ST_EMIT;
			ST_EMIT:  if (slot_free) state_d = last ? ST_DONE : ST_CHECK;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		frame.ready   = state_q == ST_IDLE;
		lerp_req.load = (state_q == ST_MUL_L) || (state_q == ST_MUL_R);
		lerp_req.a    = (state_q == ST_MUL_R) ? prev_r_q : prev_l_q;
		lerp_req.b    = (state_q == ST_MUL_R) ? cur_r_q : cur_l_q;
		lerp_req.frac = t_q[FRAC_BITS-1:0];
		emit.valid    = (state_q == ST_EMIT) && slot_free;
		emit.last     = last;
		if (cfg.linear) begin
			emit.left  = cfg.stereo ? res_l_q : lerp_result;
			emit.right = cfg.stereo ? lerp_result : '0;
		end else begin
			emit.left  = cur_l_q;
			emit.right = cur_r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			t_q         <= '0;
			limit_q     <= '0;
			n_q         <= '0;
			phase_q     <= '0;
			have_prev_q <= 1'b0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (frame.valid) begin
						t_q     <= phase_q;
						limit_q <= limit_sel;
						n_q     <= '0;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						t_q <= t_next;
						n_q <= n_q + RUN_W'(1);
					end
				end
				ST_DONE: begin
					prev_l_q <= cur_l_q;
					prev_r_q <= cur_r_q;
					if (eob_q) begin
						phase_q     <= '0;
						have_prev_q <= 1'b0;
					end else begin
						phase_q     <= have_prev_q ? t_fin - ONE_POS : t_fin;
						have_prev_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && frame.valid) begin
			cur_l_q <= frame.in_left;
			cur_r_q <= cfg.stereo ? frame.in_right : '0;
			eob_q   <= frame.end_of_block;
		end
		// hold the left result while the unit works on the right one
		if (state_q == ST_MUL_R)
			res_l_q <= lerp_result;
	end

endmodule

>>> src/audio_rate_resampler.sv
`timescale 1ns / 1ps
// Top level of the audio rate resampler: configuration, sequencer, shared unit, output register.
//
//   channel   direction   word
//   frame     in          in_left, in_right, end_of_block
//   result    out         out_left, out_right, last_of_run
//   wr_*      in          register write: wr_index selects, wr_data carries the value
//
// A frame goes from idle through a check, the multiply steps and an emit per result, then
// to done; point mode has no multiply step, linear mono a left multiply and linear stereo
// a left and a right multiply, since both channels go through one multiplier in turn;
// a frame with no result goes from its check straight to done.
// The output register lets a result wait while the next one is computed; a stall
// holds the sequencer only when that register is still full.
// Reset clears the configuration to 1.0 step, point mode, mono, and the phase to zero.
module audio_rate_resampler import arr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  reg_idx_t         wr_index,
	input  logic [CFG_W-1:0] wr_data,
	arr_frame_if.sink        frame,
	arr_result_if.source     result
);

	logic [STEP_W-1:0] phase_step_q;
	logic              interp_mode_q;
	logic [CHAN_W-1:0] channel_count_q;
	cfg_t              cfg;
	lerp_req_t         lerp_req;
	sample_t           lerp_result;
	emit_t             emit;
	logic              slot_free;
	logic              out_valid_q;
	sample_t           out_left_q, out_right_q;
	logic              out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= STEP_RESET;
			interp_mode_q   <= 1'b0;
			channel_count_q <= CHAN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_PHASE_STEP:    phase_step_q    <= wr_data[STEP_W-1:0];
				REG_INTERP_MODE:   interp_mode_q   <= wr_data[0];
				REG_CHANNEL_COUNT: channel_count_q <= wr_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.phase_step = phase_step_q;
	assign cfg.linear     = interp_mode_q == MODE_LINEAR;
	assign cfg.stereo     = channel_count_q == CHAN_STEREO;

	arr_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.frame       (frame),
		.slot_free   (slot_free),
		.lerp_result (lerp_result),
		.lerp_req    (lerp_req),
		.emit        (emit)
	);

	arr_lerp_unit u_lerp (
		.clk    (clk),
		.req    (lerp_req),
		.result (lerp_result)
	);

	assign slot_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit.valid)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_left_q  <= emit.left;
			out_right_q <= emit.right;
			out_last_q  <= emit.last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_left    = out_left_q;
	assign result.out_right   = out_right_q;
	assign result.last_of_run = out_last_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.ready |=> !frame.ready)
		else $error("frame taken while previous frame still in work");

	a_mono_right_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && channel_count_q != CHAN_STEREO |-> result.out_right == '0)
		else $error("nonzero right sample in mono");

	a_emit_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> !frame.ready)
		else $error("result produced while idle");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid && emit.last |=> !emit.valid)
		else $error("result produced after the last of its run");
`endif

endmodule
